// ===== sv/assert_macros.svh =====
// Assertion macros shared by the frame difference motion RTL.
// Plain text macros only; no package or module dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/fdm_pkg.sv =====
// Shared widths, register codes, stage types and helpers for frame_difference_motion.
// No dependencies.
`timescale 1ns / 1ps

package fdm_pkg;

    localparam int CH_W           = 8;
    localparam int NUM_CH         = 3;
    localparam int FP_W           = 17;
    localparam int IDX_W          = 2;
    localparam int NUM_W          = 2 * CH_W;
    localparam int Q_W            = 8;
    localparam int DIV_STAGES     = 4;
    localparam int BITS_PER_STAGE = Q_W / DIV_STAGES;
    localparam int MAX_PIXELS_DEF = 65536;

    localparam logic [IDX_W-1:0] REG_FRAME_PIXELS = 2'd0;
    localparam logic [IDX_W-1:0] REG_MIN_BRIGHT   = 2'd1;
    localparam logic [IDX_W-1:0] REG_RATIO_GAIN   = 2'd2;

    localparam logic [FP_W-1:0] FRAME_PIXELS_RST = 17'd65536;
    localparam logic [CH_W-1:0] MIN_BRIGHT_RST   = 8'd10;
    localparam logic [CH_W-1:0] RATIO_GAIN_RST   = 8'd100;

    // Channel 0 red, 1 green, 2 blue.
    typedef logic [NUM_CH-1:0][CH_W-1:0] t_pix;

    typedef struct packed {
        t_pix cur;
        t_pix prev;
        logic cmp;
        logic eof;
    } t_s1;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [CH_W-1:0]  lo1;
        logic [Q_W-1:0]   quo;
        logic             sat;
    } t_lane;

    typedef struct packed {
        t_lane [NUM_CH-1:0] lane;
        logic [CH_W-1:0]    diff;
        logic               bright;
        logic               cmp;
        logic               eof;
    } t_work;

    function automatic logic [CH_W-1:0] max3(input t_pix v);
        logic [CH_W-1:0] m;
        m = v[0];
        if (v[1] > m) m = v[1];
        if (v[2] > m) m = v[2];
        return m;
    endfunction

endpackage

// ===== sv/fdm_intf.sv =====
// Handshake channels of frame_difference_motion: pixel in, result out, register write.
// Depends on fdm_pkg.
`timescale 1ns / 1ps

interface fdm_pix_if import fdm_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface fdm_res_if import fdm_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] max_abs_diff;
    logic [CH_W-1:0] ratio_score;
    logic            compare_valid;
    logic            end_of_frame;

    modport source (output valid, max_abs_diff, ratio_score, compare_valid, end_of_frame,
                    input ready);
    modport sink   (input valid, max_abs_diff, ratio_score, compare_valid, end_of_frame,
                    output ready);
endinterface

interface fdm_cfg_if import fdm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [FP_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/fdm_frame_store.sv =====
// Frame store, raster position counter and stored-frame flag (pipeline stage 1).
// Depends on fdm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fdm_frame_store import fdm_pkg::*; #(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic [FP_W-1:0] i_frame_pixels,
    input  logic            i_acc,
    input  t_pix            i_pix,
    output t_s1             o_s1
);

    localparam int AW = $clog2(MAX_PIXELS);
    localparam int SW = (AW + 1 > FP_W) ? AW + 1 : FP_W;

    logic [NUM_CH*CH_W-1:0] r_mem [MAX_PIXELS];
    logic [NUM_CH*CH_W-1:0] r_rd;
    logic [AW-1:0]          r_pos;
    logic                   r_prev_valid;
    t_pix                   r_cur;
    logic                   r_cmp;
    logic                   r_eof;

    logic [SW-1:0] fp_ext;
    logic [SW-1:0] max_ext;
    logic [SW-1:0] size;
    logic [AW-1:0] last_pos;
    logic          eof;

    // Clamp the frame size to 1..MAX_PIXELS.
    always_comb begin
        fp_ext   = SW'(i_frame_pixels);
        max_ext  = SW'(MAX_PIXELS);
        size     = (fp_ext == '0) ? SW'(1) : ((fp_ext > max_ext) ? max_ext : fp_ext);
        last_pos = AW'(size - SW'(1));
        eof      = (r_pos == last_pos);
    end

    // Read-first: the read returns the previous frame's pixel at this position.
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_rd         <= r_mem[r_pos];
            r_mem[r_pos] <= i_pix;
            r_cur        <= i_pix;
            r_cmp        <= r_prev_valid;
            r_eof        <= eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_prev_valid <= 1'b0;
        end else if (i_clear) begin
            r_pos        <= '0;
            r_prev_valid <= 1'b0;
        end else if (i_acc) begin
            if (eof) begin
                r_pos        <= '0;
                r_prev_valid <= 1'b1;
            end else begin
                r_pos <= r_pos + AW'(1);
            end
        end
    end

    assign o_s1.cur  = r_cur;
    assign o_s1.prev = r_rd;
    assign o_s1.cmp  = r_cmp;
    assign o_s1.eof  = r_eof;

    `ASSERT_NEXT(a_clear_restarts, i_clk, i_rst_n, i_clear, r_pos == '0 && !r_prev_valid)
    `ASSERT_NEXT(a_pos_advances, i_clk, i_rst_n, i_acc && !eof && !i_clear, r_pos == $past(r_pos) + 1'b1)

endmodule

// ===== sv/fdm_score_prep.sv =====
// Stage 2: channel differences, brightness test, ratio numerators and divisors.
// Depends on fdm_pkg.
`timescale 1ns / 1ps

module fdm_score_prep import fdm_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  t_s1             i_s1,
    input  logic [CH_W-1:0] i_min_bright,
    input  logic [CH_W-1:0] i_gain,
    output t_work           o_work
);

    t_work r_work;
    t_work n_work;

    always_comb begin
        t_pix            ad;
        logic [CH_W-1:0] cur;
        logic [CH_W-1:0] prv;
        logic [CH_W-1:0] hi;
        logic [CH_W-1:0] lo;
        logic [CH_W-1:0] lo1;
        logic [CH_W-1:0] d;
        n_work        = '0;
        n_work.bright = 1'b1;
        for (int c = 0; c < NUM_CH; c++) begin
            cur   = i_s1.cur[c];
            prv   = i_s1.prev[c];
            ad[c] = (cur > prv) ? cur - prv : prv - cur;
            hi    = (cur > prv) ? cur : prv;
            lo    = (cur > prv) ? prv : cur;
            lo1   = (lo == '0) ? CH_W'(1) : lo;
            d     = (hi > lo1) ? hi - lo1 : '0;
            n_work.lane[c].rem = NUM_W'(i_gain) * NUM_W'(d);
            n_work.lane[c].lo1 = lo1;
            if (!(cur > i_min_bright && prv > i_min_bright)) n_work.bright = 1'b0;
        end
        n_work.diff = i_s1.cmp ? max3(ad) : '0;
        n_work.cmp  = i_s1.cmp;
        n_work.eof  = i_s1.eof;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_work <= n_work;
    end

    assign o_work = r_work;

endmodule

// ===== sv/fdm_div_stage.sv =====
// One stage of the restoring divider: BITS_PER_STAGE (two) quotient bits per channel lane.
// Depends on fdm_pkg.
`timescale 1ns / 1ps

module fdm_div_stage import fdm_pkg::*; #(
    parameter int STEP_HI = Q_W - 1
) (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_work i_work,
    output t_work o_work
);

    t_work r_work;
    t_work n_work;

    always_comb begin
        t_lane            ln;
        logic [NUM_W-1:0] trial;
        n_work = i_work;
        for (int c = 0; c < NUM_CH; c++) begin
            ln = i_work.lane[c];
            // A quotient of 256 or more saturates; flag it before the first bit.
            if (STEP_HI == Q_W - 1) ln.sat = (ln.rem >= {ln.lo1, CH_W'(0)});
            for (int j = 0; j < BITS_PER_STAGE; j++) begin
                trial = NUM_W'(ln.lo1) << (STEP_HI - j);
                if (ln.rem >= trial) begin
                    ln.rem              = ln.rem - trial;
                    ln.quo[STEP_HI - j] = 1'b1;
                end
            end
            n_work.lane[c] = ln;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_work <= n_work;
    end

    assign o_work = r_work;

endmodule

// ===== sv/frame_difference_motion.sv =====
// Frame difference motion detector: frame store, prep, divider and output register stages.
// One pixel word per cycle unless stalled; the frame store does one read and one write per pixel.
// Each stage stalls only while it is full and the next one cannot take, so bubbles absorb stalls.
// Reset (synchronous, active low) empties the pipeline, returns position and stored-frame flag
// to zero and loads register defaults; the frame store is not cleared, compare_valid masks it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frame_difference_motion import fdm_pkg::*; #(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fdm_pix_if.sink    i_pix,
    fdm_res_if.source  o_res,
    fdm_cfg_if.sink    i_cfg
);

    // Stage map: 0 frame store, 1 prep, 2..DIV_STAGES+1 divider, last output register.
    localparam int NSTG = DIV_STAGES + 3;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] stg_en;
    logic            pix_acc;
    logic            cfg_acc;
    logic            clear;

    logic [FP_W-1:0] r_frame_pixels;
    logic [CH_W-1:0] r_min_bright;
    logic [CH_W-1:0] r_ratio_gain;

    t_pix            pix_in;
    t_s1             s1;
    t_work           w_div [DIV_STAGES + 1];

    t_pix            q;
    logic [CH_W-1:0] n_score;
    logic [CH_W-1:0] r_diff;
    logic [CH_W-1:0] r_score;
    logic            r_cmp;
    logic            r_eof;

    // ---------------- register writes ----------------
    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign clear       = cfg_acc && (i_cfg.index == REG_FRAME_PIXELS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pixels <= FRAME_PIXELS_RST;
            r_min_bright   <= MIN_BRIGHT_RST;
            r_ratio_gain   <= RATIO_GAIN_RST;
        end else if (cfg_acc) begin
            case (i_cfg.index)
                REG_FRAME_PIXELS: r_frame_pixels <= i_cfg.data;
                REG_MIN_BRIGHT:   r_min_bright   <= i_cfg.data[CH_W-1:0];
                REG_RATIO_GAIN:   r_ratio_gain   <= i_cfg.data[CH_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        stg_en[NSTG-1] = !r_vld[NSTG-1] || o_res.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    assign i_pix.ready = stg_en[0];
    assign pix_acc     = i_pix.valid && stg_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) r_vld[0] <= pix_acc;
            for (int k = 1; k < NSTG; k++) begin
                if (stg_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // ---------------- datapath ----------------
    assign pix_in[0] = i_pix.red;
    assign pix_in[1] = i_pix.green;
    assign pix_in[2] = i_pix.blue;

    fdm_frame_store #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_store (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_clear        (clear),
        .i_frame_pixels (r_frame_pixels),
        .i_acc          (pix_acc),
        .i_pix          (pix_in),
        .o_s1           (s1)
    );

    fdm_score_prep u_prep (
        .i_clk        (i_clk),
        .i_en         (stg_en[1]),
        .i_s1         (s1),
        .i_min_bright (r_min_bright),
        .i_gain       (r_ratio_gain),
        .o_work       (w_div[0])
    );

    // Divider: BITS_PER_STAGE quotient bits per stage, most significant first.
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        fdm_div_stage #(
            .STEP_HI (Q_W - 1 - k * BITS_PER_STAGE)
        ) u_div (
            .i_clk  (i_clk),
            .i_en   (stg_en[k + 2]),
            .i_work (w_div[k]),
            .o_work (w_div[k + 1])
        );
    end

    // Saturate each lane, take the largest, zero it unless bright and comparable.
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            q[c] = w_div[DIV_STAGES].lane[c].sat ? '1 : w_div[DIV_STAGES].lane[c].quo;
        end
        n_score = (w_div[DIV_STAGES].bright && w_div[DIV_STAGES].cmp) ? max3(q) : '0;
    end

    // Output register: hold while the sink stalls.
    always_ff @(posedge i_clk) begin
        if (stg_en[NSTG-1]) begin
            r_diff  <= w_div[DIV_STAGES].diff;
            r_score <= n_score;
            r_cmp   <= w_div[DIV_STAGES].cmp;
            r_eof   <= w_div[DIV_STAGES].eof;
        end
    end

    assign o_res.valid         = r_vld[NSTG-1];
    assign o_res.max_abs_diff  = r_diff;
    assign o_res.ratio_score   = r_score;
    assign o_res.compare_valid = r_cmp;
    assign o_res.end_of_frame  = r_eof;

    `ASSERT_IMPLIES(a_mask_without_frame, i_clk, i_rst_n, o_res.valid && !o_res.compare_valid, o_res.max_abs_diff == '0 && o_res.ratio_score == '0)
    `ASSERT_IMPLIES(a_take_into_bubble, i_clk, i_rst_n, !r_vld[0], i_pix.ready)

endmodule

// ===== bench/frame_difference_motion_tb.sv =====
// Self-checking bench for frame_difference_motion: directed table, then random frames.
// Depends on fdm_pkg, the fdm_*_if interfaces and the frame_difference_motion RTL.
`timescale 1ns / 1ps

module frame_difference_motion_tb;
    import fdm_pkg::*;

    localparam int MAX_FRAME     = MAX_PIXELS_DEF;
    localparam int NUM_DIRECTED  = 35;
    localparam int RANDOM_WORDS  = 1450;
    localparam int FINAL_WORDS   = 64;
    localparam int TAIL_CYCLES   = 32;
    localparam int CYCLE_LIMIT   = 400_000;

    // Index 3 is not a register; a write there must leave everything alone.
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0] max_abs_diff;
        logic [CH_W-1:0] ratio_score;
        logic            compare_valid;
        logic            end_of_frame;
    } t_motion_result;

    typedef enum logic {ROW_PIXEL, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [IDX_W-1:0] idx;
        logic [FP_W-1:0]  data;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic             typed;
        t_motion_result   want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fdm_pix_if pix_bus ();
    fdm_res_if res_bus ();
    fdm_cfg_if cfg_bus ();

    frame_difference_motion dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    always #5 i_clk = ~i_clk;

    // Mirror of the block: frame store, raster position, stored-frame flag and registers.
    bit [CH_W-1:0] stored_red   [MAX_FRAME];
    bit [CH_W-1:0] stored_green [MAX_FRAME];
    bit [CH_W-1:0] stored_blue  [MAX_FRAME];
    int unsigned   raster_pos = 0;
    bit            frame_full = 1'b0;
    bit [FP_W-1:0] frame_pixels_q = FRAME_PIXELS_RST;
    bit [CH_W-1:0] min_bright_q   = MIN_BRIGHT_RST;
    bit [CH_W-1:0] gain_q         = RATIO_GAIN_RST;

    t_motion_result pending_results [$];
    int             mismatches = 0;
    bit             gaps_on = 1'b1;

    function automatic t_stim_row pix_row(input logic [CH_W-1:0] r, g, b);
        return '{ROW_PIXEL, '0, '0, r, g, b, 1'b0, '0};
    endfunction

    function automatic t_stim_row chk_row(input logic [CH_W-1:0] r, g, b,
                                          input logic [CH_W-1:0] diff, score,
                                          input logic cmp, eof);
        return '{ROW_PIXEL, '0, '0, r, g, b, 1'b1, '{diff, score, cmp, eof}};
    endfunction

    function automatic t_stim_row reg_row(input logic [IDX_W-1:0] idx,
                                          input logic [FP_W-1:0] data);
        return '{ROW_REG, idx, data, 8'd0, 8'd0, 8'd0, 1'b0, '0};
    endfunction

    // Directed table. Rows with a typed result hold only values that are plain at a glance:
    // no stored frame, end of frame, full-scale difference on a dark pixel.
    t_stim_row directed_rows [NUM_DIRECTED] = '{
        // Reset defaults: 65536-pixel frame, nothing stored yet.
        chk_row(8'd0,   8'd0,   8'd0,   8'd0,   8'd0, 1'b0, 1'b0),
        chk_row(8'd255, 8'd255, 8'd255, 8'd0,   8'd0, 1'b0, 1'b0),
        reg_row(REG_UNUSED, 17'h1FFFF),
        // One-pixel frames: every word ends a frame.
        reg_row(REG_FRAME_PIXELS, 17'd1),
        chk_row(8'd100, 8'd100, 8'd100, 8'd0,   8'd0, 1'b0, 1'b1),
        pix_row(8'd200, 8'd100, 8'd50),
        pix_row(8'd255, 8'd255, 8'd255),
        chk_row(8'd0,   8'd0,   8'd0,   8'd255, 8'd0, 1'b1, 1'b1),
        // Zero threshold, full gain: two zero channels score nothing.
        reg_row(REG_MIN_BRIGHT, 17'd0),
        reg_row(REG_RATIO_GAIN, 17'd255),
        chk_row(8'd0,   8'd0,   8'd0,   8'd0,   8'd0, 1'b1, 1'b1),
        pix_row(8'd1,   8'd1,   8'd1),
        pix_row(8'd255, 8'd255, 8'd255),
        pix_row(8'd254, 8'd128, 8'd2),
        // Top threshold: nothing is ever bright enough.
        reg_row(REG_MIN_BRIGHT, 17'd255),
        pix_row(8'd255, 8'd255, 8'd255),
        reg_row(REG_RATIO_GAIN, 17'd0),
        reg_row(REG_MIN_BRIGHT, 17'd10),
        pix_row(8'd20,  8'd40,  8'd80),
        // Zero frame size behaves as a single pixel.
        reg_row(REG_FRAME_PIXELS, 17'd0),
        chk_row(8'd7,   8'd8,   8'd9,   8'd0,   8'd0, 1'b0, 1'b1),
        pix_row(8'd9,   8'd8,   8'd7),
        // Three-pixel frames with threshold edge cases.
        reg_row(REG_FRAME_PIXELS, 17'd3),
        reg_row(REG_RATIO_GAIN, 17'd100),
        chk_row(8'd11,  8'd11,  8'd11,  8'd0,   8'd0, 1'b0, 1'b0),
        chk_row(8'd12,  8'd12,  8'd12,  8'd0,   8'd0, 1'b0, 1'b0),
        chk_row(8'd13,  8'd13,  8'd13,  8'd0,   8'd0, 1'b0, 1'b1),
        pix_row(8'd11,  8'd22,  8'd33),
        pix_row(8'd6,   8'd12,  8'd255),
        pix_row(8'd14,  8'd14,  8'd13),
        reg_row(REG_MIN_BRIGHT, 17'd11),
        pix_row(8'd11,  8'd200, 8'd200),
        // Oversized frame clamps to the full store.
        reg_row(REG_FRAME_PIXELS, 17'h1FFFF),
        chk_row(8'd1,   8'd2,   8'd3,   8'd0,   8'd0, 1'b0, 1'b0),
        chk_row(8'd4,   8'd5,   8'd6,   8'd0,   8'd0, 1'b0, 1'b0)
    };

    function automatic int unsigned active_frame_len();
        if (frame_pixels_q == 0) return 1;
        if (frame_pixels_q > MAX_FRAME) return MAX_FRAME;
        return frame_pixels_q;
    endfunction

    function automatic int unsigned store_slot();
        return (raster_pos >= active_frame_len()) ? 0 : raster_pos;
    endfunction

    function automatic void apply_reg_write(input logic [IDX_W-1:0] idx,
                                            input logic [FP_W-1:0] data);
        case (idx)
            REG_FRAME_PIXELS: begin
                // A new frame size invalidates the stored frame and restarts the raster.
                frame_pixels_q = data;
                frame_full     = 1'b0;
                raster_pos     = 0;
            end
            REG_MIN_BRIGHT: min_bright_q = data[CH_W-1:0];
            REG_RATIO_GAIN: gain_q       = data[CH_W-1:0];
            default: ;
        endcase
    endfunction

    // Compare one pixel with the stored one at its position, then store it and advance.
    function automatic t_motion_result predict_motion(input logic [CH_W-1:0] r, g, b);
        t_motion_result  out_q;
        logic [CH_W-1:0] cur [3];
        logic [CH_W-1:0] old [3];
        int unsigned     len, slot, hi, lo, lo1, ratio, best;
        bit              bright;
        len  = active_frame_len();
        slot = store_slot();
        cur  = '{r, g, b};
        old  = '{stored_red[slot], stored_green[slot], stored_blue[slot]};
        out_q  = '0;
        best   = 0;
        bright = 1'b1;
        if (frame_full) begin
            for (int k = 0; k < 3; k++) begin
                hi  = (cur[k] > old[k]) ? cur[k] : old[k];
                lo  = (cur[k] > old[k]) ? old[k] : cur[k];
                lo1 = (lo == 0) ? 1 : lo;
                if (hi - lo > out_q.max_abs_diff) out_q.max_abs_diff = CH_W'(hi - lo);
                if (cur[k] <= min_bright_q || old[k] <= min_bright_q) bright = 1'b0;
                ratio = (hi > lo1) ? (gain_q * (hi - lo1)) / lo1 : 0;
                if (ratio > best) best = ratio;
            end
            if (bright) out_q.ratio_score = (best > 255) ? 8'd255 : CH_W'(best);
            out_q.compare_valid = 1'b1;
        end
        stored_red[slot]   = r;
        stored_green[slot] = g;
        stored_blue[slot]  = b;
        out_q.end_of_frame = (slot == len - 1);
        if (out_q.end_of_frame) begin
            raster_pos = 0;
            frame_full = 1'b1;
        end else begin
            raster_pos = slot + 1;
        end
        return out_q;
    endfunction

    // Favor the extremes and small values for threshold and gain, otherwise any byte.
    function automatic logic [CH_W-1:0] pick_reg_byte();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return CH_W'($urandom_range(0, 40));
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Half the pixels are bright and close to the stored one, so the ratio path sees real work;
    // the rest is fresh bright content, full-scale channels and plain noise.
    function automatic void pick_pixel(output logic [CH_W-1:0] r, g, b);
        logic [CH_W-1:0] base [3];
        int              v [3];
        int              floor_v, spread;
        int unsigned     mode, slot;
        slot    = store_slot();
        base    = '{stored_red[slot], stored_green[slot], stored_blue[slot]};
        floor_v = int'(min_bright_q) + 1;
        mode    = $urandom_range(0, 9);
        spread  = $urandom_range(0, 1) ? 4 : 40;
        for (int k = 0; k < 3; k++) begin
            if (mode < 5) begin
                v[k] = int'(base[k]) + int'($urandom_range(0, 2 * spread)) - spread;
                if (v[k] < floor_v) v[k] = floor_v;
            end else if (mode < 7) begin
                v[k] = (floor_v > 255) ? 255 : int'($urandom_range(floor_v, 255));
            end else if (mode == 7) begin
                v[k] = $urandom_range(0, 1) ? 255 : 0;
            end else begin
                v[k] = $urandom_range(0, 255);
            end
            if (v[k] > 255) v[k] = 255;
            if (v[k] < 0) v[k] = 0;
        end
        r = v[0][CH_W-1:0];
        g = v[1][CH_W-1:0];
        b = v[2][CH_W-1:0];
    endfunction

    // Offer one pixel word, optionally after a gap, and queue its expected result once taken.
    task automatic send_pixel(input logic [CH_W-1:0] r, g, b, input bit typed,
                              input t_motion_result typed_want);
        t_motion_result predicted;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            pix_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.red   <= r;
        pix_bus.green <= g;
        pix_bus.blue  <= b;
        do @(posedge i_clk); while (!pix_bus.ready);
        predicted = predict_motion(r, g, b);
        pending_results.push_back(typed ? typed_want : predicted);
    endtask

    // Write one register word, then drive valid low again before the next write.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [FP_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        apply_reg_write(idx, data);
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering pixels and hold until every queued result has come back.
    task automatic settle_results();
        pix_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Result side: ready with random stall bursts while gaps are on.
    initial begin
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (gaps_on && $urandom_range(0, 3) == 0) begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            repeat ($urandom_range(0, 7)) @(posedge i_clk);
        end
    end

    // Check every accepted result word against the oldest expectation.
    always @(posedge i_clk) begin
        t_motion_result got, want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got = '{res_bus.max_abs_diff, res_bus.ratio_score,
                    res_bus.compare_valid, res_bus.end_of_frame};
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word diff=%0d score=%0d cmp=%0b eof=%0b",
                         $time, got.max_abs_diff, got.ratio_score,
                         got.compare_valid, got.end_of_frame);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    $display({"%0t: expected diff=%0d score=%0d cmp=%0b eof=%0b,",
                              " got diff=%0d score=%0d cmp=%0b eof=%0b"},
                             $time, want.max_abs_diff, want.ratio_score,
                             want.compare_valid, want.end_of_frame,
                             got.max_abs_diff, got.ratio_score,
                             got.compare_valid, got.end_of_frame);
                end
            end
        end
    end

    // Watchdog: end a run that stops making progress.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("frame_difference_motion regression: fail");
        $finish;
    end

    initial begin
        logic [CH_W-1:0] r, g, b;
        logic [FP_W-1:0] reg_data;
        int unsigned     frame_len, phase_words, random_words;
        t_stim_row       row;

        // Drive every input to a known value and hold reset.
        i_rst_n       <= 1'b0;
        pix_bus.valid <= 1'b0;
        pix_bus.red   <= '0;
        pix_bus.green <= '0;
        pix_bus.blue  <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= REG_FRAME_PIXELS;
        cfg_bus.data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table; register rows wait for the pipeline to drain first.
        for (int n = 0; n < NUM_DIRECTED; n++) begin
            row = directed_rows[n];
            if (row.kind == ROW_REG) begin
                settle_results();
                write_reg(row.idx, row.data);
            end else begin
                send_pixel(row.red, row.green, row.blue, row.typed, row.want);
            end
        end

        // Random phases: new settings each phase, then one to three frames of content and a partial frame.
        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            settle_results();
            gaps_on   = ($urandom_range(0, 4) != 0);
            frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300)
                                                    : $urandom_range(1, 24);
            write_reg(REG_FRAME_PIXELS, FP_W'(frame_len));
            if ($urandom_range(0, 1)) begin
                // Upper data bits are don't-care for the byte registers; toggle them anyway.
                reg_data       = FP_W'($urandom);
                reg_data[7:0]  = pick_reg_byte();
                write_reg(REG_MIN_BRIGHT, reg_data);
            end
            if ($urandom_range(0, 1)) begin
                reg_data       = FP_W'($urandom);
                reg_data[7:0]  = pick_reg_byte();
                write_reg(REG_RATIO_GAIN, reg_data);
            end
            phase_words = $urandom_range(1, 3) * frame_len + $urandom_range(0, frame_len - 1);
            repeat (phase_words) begin
                pick_pixel(r, g, b);
                send_pixel(r, g, b, 1'b0, '0);
            end
            random_words += phase_words;
        end

        // Close with back-to-back words and no stalls on either side.
        settle_results();
        gaps_on   = 1'b0;
        frame_len = $urandom_range(2, 16);
        write_reg(REG_FRAME_PIXELS, FP_W'(frame_len));
        repeat (FINAL_WORDS) begin
            pick_pixel(r, g, b);
            send_pixel(r, g, b, 1'b0, '0);
        end

        settle_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("frame_difference_motion regression: pass");
        end else begin
            $display("frame_difference_motion regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/fdm_pkg.sv
sv/fdm_intf.sv
sv/fdm_frame_store.sv
sv/fdm_score_prep.sv
sv/fdm_div_stage.sv
sv/frame_difference_motion.sv
bench/frame_difference_motion_tb.sv
